// File: rtl/core/sscl_pkg.sv
// sscl_pkg: shared types and constants for the segment split unit
// field widths, register indexes, fixed-point constants, output saturation
// no dependencies
package sscl_pkg;

  localparam int COORD_W    = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;
  localparam int LINE_W     = 48;
  localparam int COEF_W     = 16;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int T_W        = 17;
  localparam int PIECE_W    = 16;
  localparam int REGION_W   = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_LINE0 = 3'd1;

  // reset value of cut_count
  localparam logic [CNT_W-1:0] CUT_COUNT_RST = 3'd2;

  // near-zero denominator bound and its replacement (Q1.14 one)
  localparam int DEN_EPS = 16;
  localparam int Q14_ONE = 16384;

  // t of the end point, Q1.16 one
  localparam logic [T_W-1:0] T_ONE = 17'h10000;

  // one input segment
  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic                      last;
  } seg_t;

  // clamp to the signed 16-bit range
  function automatic logic [PIECE_W-1:0] sat16(input logic signed [31:0] v);
    logic [PIECE_W-1:0] r;
    if (v > 32'sd32767) begin
      r = 16'h7fff;
    end else if (v < -32'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[PIECE_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/segment_split_by_cut_lines_unit.sv
// segment_split_by_cut_lines_unit: splits a 2D segment at up to four cut lines
// and streams the pieces in order along the segment; single module
// depends on sscl_pkg
//
// throughput: one piece per cycle while the output is not stalled, from the piece
//   emitter that feeds the one result channel; an item yields 1..5 pieces
// front: 12 stages (products, distances, 6-stage divider, t, delta products,
//   cut points, sort)
// reset: clears valid bits and emitter, cut_count to 2, cut lines to 0
module segment_split_by_cut_lines_unit #(
  parameter int NUM_LINES       = 4,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // tdata: start_x, start_y, end_x, end_y; tlast: last_segment
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sscl_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tlast,
  // tdata: piece_start_x, piece_start_y, piece_end_x, piece_end_y,
  //        start_is_cut, end_is_cut, region_code, 2 zero bits
  // tlast: last_piece; tuser: end_of_model
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sscl_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  output logic                                out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sscl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sscl_pkg::LINE_W-1:0]         cfg_data
);
  import sscl_pkg::*;

  localparam int F      = COORD_FRAC_BITS;
  localparam int CW     = F + 10;
  localparam int SW     = CW + 1;
  localparam int RPW    = COEF_W + SW;
  localparam int DW     = F + 29;
  localparam int DLW    = 26;
  localparam int DNW    = 27;
  localparam int DVW    = 27;
  localparam int STEPS  = 3;
  localparam int DIV_ST = 6;
  localparam int QW     = STEPS * DIV_ST;
  localparam int PXW    = 27;
  localparam int MGW    = 25 + F;
  localparam int NB     = NUM_LINES + 2;
  localparam int RKW    = $clog2(NUM_LINES + 1);
  localparam int CNW    = $clog2(NB);
  localparam int NFS    = 12;

  // configuration registers
  logic [CNT_W-1:0]          cut_count_r;
  logic [LINE_W-1:0]         line_r [NUM_LINES];
  logic signed [COEF_W-1:0]  ca [NUM_LINES];
  logic signed [COEF_W-1:0]  cb [NUM_LINES];
  logic signed [COEF_W-1:0]  cc [NUM_LINES];
  logic [NUM_LINES-1:0]      use_m;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_count_r <= CUT_COUNT_RST;
      for (int k = 0; k < NUM_LINES; k++) line_r[k] <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_CUT_COUNT) cut_count_r <= cfg_data[CNT_W-1:0];
      for (int k = 0; k < NUM_LINES; k++) begin
        if (cfg_index == CFG_CUT_LINE0 + CFG_IDX_W'(k)) line_r[k] <= cfg_data;
      end
    end
  end

  // coefficient fields and lines in use
  always_comb begin
    for (int k = 0; k < NUM_LINES; k++) begin
      ca[k]    = line_r[k][47:32];
      cb[k]    = line_r[k][31:16];
      cc[k]    = line_r[k][15:0];
      use_m[k] = CNT_W'(k) < cut_count_r;
    end
  end

  // stall control: back end moves when the output is free, front when the
  // emitter can take a new item
  logic            back_en;
  logic            fe;
  logic            out_valid_r;
  logic            em_busy_r;
  logic [CNW-1:0]  em_cnt_r;

  assign back_en   = !out_valid_r || out_tready;
  assign fe        = back_en && (!em_busy_r || em_cnt_r == CNW'(1));
  assign in_tready = fe;

  // front valid bits and segment carried along
  logic  fv_r [NFS];
  seg_t  seg_r [NFS];
  seg_t  in_seg;

  always_comb begin
    in_seg.x1   = in_tdata[7:0];
    in_seg.y1   = in_tdata[15:8];
    in_seg.x2   = in_tdata[23:16];
    in_seg.y2   = in_tdata[31:24];
    in_seg.last = in_tlast;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NFS; i++) fv_r[i] <= 1'b0;
    end else if (fe) begin
      fv_r[0] <= in_tvalid;
      for (int i = 1; i < NFS; i++) fv_r[i] <= fv_r[i-1];
    end
  end

  // stage 1: coefficient products at both endpoints
  logic signed [23:0] pa1_r [NUM_LINES];
  logic signed [23:0] pb1_r [NUM_LINES];
  logic signed [23:0] pa2_r [NUM_LINES];
  logic signed [23:0] pb2_r [NUM_LINES];
  logic signed [23:0] pa1_nxt [NUM_LINES];
  logic signed [23:0] pb1_nxt [NUM_LINES];
  logic signed [23:0] pa2_nxt [NUM_LINES];
  logic signed [23:0] pb2_nxt [NUM_LINES];

  always_comb begin
    for (int k = 0; k < NUM_LINES; k++) begin
      pa1_nxt[k] = ca[k] * in_seg.x1;
      pb1_nxt[k] = cb[k] * in_seg.y1;
      pa2_nxt[k] = ca[k] * in_seg.x2;
      pb2_nxt[k] = cb[k] * in_seg.y2;
    end
  end

  // stage 2: distances, crossing test, divider operands
  logic [DVW-1:0]  f2_rem [NUM_LINES];
  logic [DVW-1:0]  f2_den [NUM_LINES];
  logic            f2_zero [NUM_LINES];
  logic            f2_cross [NUM_LINES];

  always_comb begin
    logic signed [DLW-1:0] d1;
    logic signed [DLW-1:0] d2;
    logic signed [DNW-1:0] den;
    logic [DNW-1:0]        aden;
    logic                  neg1, pos1, neg2, pos2, near_zero;
    for (int k = 0; k < NUM_LINES; k++) begin
      d1    = DLW'(pa1_r[k]) + DLW'(pb1_r[k]) + (DLW'(cc[k]) <<< 8);
      d2    = DLW'(pa2_r[k]) + DLW'(pb2_r[k]) + (DLW'(cc[k]) <<< 8);
      neg1  = d1[DLW-1];
      pos1  = !neg1 && (d1 != '0);
      neg2  = d2[DLW-1];
      pos2  = !neg2 && (d2 != '0);
      den   = DNW'(d1) - DNW'(d2);
      aden  = den[DNW-1] ? DNW'(-den) : DNW'(den);
      near_zero = aden <= DNW'(DEN_EPS);
      f2_cross[k] = use_m[k] && ((neg1 && pos2) || (pos1 && neg2));
      f2_den[k]   = near_zero ? DVW'(Q14_ONE) : DVW'(aden);
      f2_rem[k]   = neg1 ? DVW'(-d1) : DVW'(d1);
      f2_zero[k]  = near_zero && neg1;
    end
  end

  // stages 3..8: restoring divider, three quotient bits per stage
  logic [DVW-1:0]  dv_rem_r   [DIV_ST+1][NUM_LINES];
  logic [DVW-1:0]  dv_den_r   [DIV_ST+1][NUM_LINES];
  logic [QW-1:0]   dv_q_r     [DIV_ST+1][NUM_LINES];
  logic            dv_zero_r  [DIV_ST+1][NUM_LINES];
  logic            dv_cross_r [DIV_ST+1][NUM_LINES];
  logic [DVW-1:0]  dv_rem_nxt [DIV_ST][NUM_LINES];
  logic [QW-1:0]   dv_q_nxt   [DIV_ST][NUM_LINES];

  always_comb begin
    logic [DVW-1:0] r;
    logic [QW-1:0]  q;
    for (int j = 0; j < DIV_ST; j++) begin
      for (int k = 0; k < NUM_LINES; k++) begin
        r = dv_rem_r[j][k];
        q = dv_q_r[j][k];
        for (int s = 0; s < STEPS; s++) begin
          r = r << 1;
          q = q << 1;
          if (r >= dv_den_r[j][k]) begin
            r    = r - dv_den_r[j][k];
            q[0] = 1'b1;
          end
        end
        dv_rem_nxt[j][k] = r;
        dv_q_nxt[j][k]   = q;
      end
    end
  end

  // stage 9: round the quotient to t in Q1.16
  logic [T_W-1:0] t_r [NUM_LINES];
  logic           tc_r [NUM_LINES];
  logic [T_W-1:0] t_nxt [NUM_LINES];

  always_comb begin
    logic [QW:0] tq;
    for (int k = 0; k < NUM_LINES; k++) begin
      tq       = {1'b0, dv_q_r[DIV_ST][k]} + (QW+1)'(2);
      t_nxt[k] = dv_zero_r[DIV_ST][k] ? '0 : tq[QW:2];
    end
  end

  // stage 10: t times the endpoint deltas
  logic signed [PXW-1:0] px_r [NUM_LINES];
  logic signed [PXW-1:0] py_r [NUM_LINES];
  logic [T_W-1:0]        t2_r [NUM_LINES];
  logic                  tc2_r [NUM_LINES];
  logic signed [PXW-1:0] px_nxt [NUM_LINES];
  logic signed [PXW-1:0] py_nxt [NUM_LINES];

  always_comb begin
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    dx = 9'(seg_r[8].x2) - 9'(seg_r[8].x1);
    dy = 9'(seg_r[8].y2) - 9'(seg_r[8].y1);
    for (int k = 0; k < NUM_LINES; k++) begin
      px_nxt[k] = $signed({1'b0, t_r[k]}) * dx;
      py_nxt[k] = $signed({1'b0, t_r[k]}) * dy;
    end
  end

  // stage 11: cut points with rounding away from zero, sort ranks
  logic signed [CW-1:0] cx_r [NUM_LINES];
  logic signed [CW-1:0] cy_r [NUM_LINES];
  logic [T_W-1:0]       t3_r [NUM_LINES];
  logic                 tc3_r [NUM_LINES];
  logic [RKW-1:0]       rank_r [NUM_LINES];
  logic signed [CW-1:0] cx_nxt [NUM_LINES];
  logic signed [CW-1:0] cy_nxt [NUM_LINES];
  logic [RKW-1:0]       rank_nxt [NUM_LINES];

  function automatic logic signed [CW-1:0] interp_pt(
    input logic signed [COORD_W-1:0] p1,
    input logic signed [PXW-1:0]     prod
  );
    logic [PXW-1:0]       pm;
    logic [MGW-1:0]       rnd;
    logic signed [CW-1:0] off;
    pm  = prod[PXW-1] ? PXW'(-prod) : PXW'(prod);
    rnd = (MGW'(pm) << F) + MGW'(32768);
    off = CW'(rnd >> 16);
    return (CW'(p1) <<< F) + (prod[PXW-1] ? -off : off);
  endfunction

  always_comb begin
    for (int k = 0; k < NUM_LINES; k++) begin
      cx_nxt[k]   = interp_pt(seg_r[9].x1, px_r[k]);
      cy_nxt[k]   = interp_pt(seg_r[9].y1, py_r[k]);
      rank_nxt[k] = '0;
      for (int j = 0; j < NUM_LINES; j++) begin
        if (j != k && tc2_r[j] &&
            (t2_r[j] < t2_r[k] || (t2_r[j] == t2_r[k] && j < k))) begin
          rank_nxt[k] = rank_nxt[k] + RKW'(1);
        end
      end
    end
  end

  // stage 12: boundary list ordered along the segment
  logic signed [CW-1:0] bx_r [NB];
  logic signed [CW-1:0] by_r [NB];
  logic [T_W-1:0]       bt_r [NB];
  logic                 bc_r [NB];
  logic                 bp_r [NB];
  logic signed [CW-1:0] bx_nxt [NB];
  logic signed [CW-1:0] by_nxt [NB];
  logic [T_W-1:0]       bt_nxt [NB];
  logic                 bc_nxt [NB];
  logic                 bp_nxt [NB];

  always_comb begin
    int m;
    m = 0;
    for (int k = 0; k < NUM_LINES; k++) m = m + int'(tc3_r[k]);
    for (int s = 0; s < NB; s++) begin
      bx_nxt[s] = '0;
      by_nxt[s] = '0;
      bt_nxt[s] = '0;
      bc_nxt[s] = 1'b0;
      bp_nxt[s] = 1'b0;
      if (s == 0) begin
        bx_nxt[s] = CW'(seg_r[10].x1) <<< F;
        by_nxt[s] = CW'(seg_r[10].y1) <<< F;
        bp_nxt[s] = 1'b1;
      end else if (s - 1 < m) begin
        for (int k = 0; k < NUM_LINES; k++) begin
          if (tc3_r[k] && int'(rank_r[k]) == s - 1) begin
            bx_nxt[s] = cx_r[k];
            by_nxt[s] = cy_r[k];
            bt_nxt[s] = t3_r[k];
          end
        end
        bc_nxt[s] = 1'b1;
        bp_nxt[s] = 1'b1;
      end else if (s == m + 1) begin
        bx_nxt[s] = CW'(seg_r[10].x2) <<< F;
        by_nxt[s] = CW'(seg_r[10].y2) <<< F;
        bt_nxt[s] = T_ONE;
        bp_nxt[s] = 1'b1;
      end
    end
  end

  // front payload registers
  always_ff @(posedge clk) begin
    if (fe) begin
      seg_r[0] <= in_seg;
      for (int i = 1; i < NFS; i++) seg_r[i] <= seg_r[i-1];
      pa1_r <= pa1_nxt;
      pb1_r <= pb1_nxt;
      pa2_r <= pa2_nxt;
      pb2_r <= pb2_nxt;
      for (int k = 0; k < NUM_LINES; k++) begin
        dv_rem_r[0][k]   <= f2_rem[k];
        dv_den_r[0][k]   <= f2_den[k];
        dv_q_r[0][k]     <= '0;
        dv_zero_r[0][k]  <= f2_zero[k];
        dv_cross_r[0][k] <= f2_cross[k];
        for (int j = 0; j < DIV_ST; j++) begin
          dv_rem_r[j+1][k]   <= dv_rem_nxt[j][k];
          dv_den_r[j+1][k]   <= dv_den_r[j][k];
          dv_q_r[j+1][k]     <= dv_q_nxt[j][k];
          dv_zero_r[j+1][k]  <= dv_zero_r[j][k];
          dv_cross_r[j+1][k] <= dv_cross_r[j][k];
        end
        t_r[k]    <= t_nxt[k];
        tc_r[k]   <= dv_cross_r[DIV_ST][k];
        px_r[k]   <= px_nxt[k];
        py_r[k]   <= py_nxt[k];
        t2_r[k]   <= t_r[k];
        tc2_r[k]  <= tc_r[k];
        cx_r[k]   <= cx_nxt[k];
        cy_r[k]   <= cy_nxt[k];
        t3_r[k]   <= t2_r[k];
        tc3_r[k]  <= tc2_r[k];
        rank_r[k] <= rank_nxt[k];
      end
      bx_r <= bx_nxt;
      by_r <= by_nxt;
      bt_r <= bt_nxt;
      bc_r <= bc_nxt;
      bp_r <= bp_nxt;
    end
  end

  // emitter load: drop boundaries that do not advance t, then compact
  logic signed [CW-1:0] ld_x [NB];
  logic signed [CW-1:0] ld_y [NB];
  logic                 ld_c [NB];
  logic [CNW-1:0]       ld_cnt;

  always_comb begin
    logic [NB-1:0] keep;
    int            pos;
    keep[0] = 1'b1;
    for (int s = 1; s < NB; s++) keep[s] = bp_r[s] && (bt_r[s] > bt_r[s-1]);
    for (int o = 0; o < NB; o++) begin
      ld_x[o] = '0;
      ld_y[o] = '0;
      ld_c[o] = 1'b0;
    end
    pos = 0;
    for (int s = 0; s < NB; s++) begin
      for (int o = 0; o < NB; o++) begin
        if (keep[s] && pos == o) begin
          ld_x[o] = bx_r[s];
          ld_y[o] = by_r[s];
          ld_c[o] = bc_r[s];
        end
      end
      pos = pos + int'(keep[s]);
    end
    ld_cnt = CNW'(pos - 1);
  end

  // piece emitter: shifts its boundary list down once per piece
  logic signed [CW-1:0] ex_r [NB];
  logic signed [CW-1:0] ey_r [NB];
  logic                 ec_r [NB];
  logic                 em_last_r;
  logic                 em_take;
  logic                 em_fire;
  logic                 em_busy_nxt;
  logic [CNW-1:0]       em_cnt_nxt;

  assign em_take = fe && fv_r[NFS-1];
  assign em_fire = back_en && em_busy_r;

  always_comb begin
    em_busy_nxt = em_busy_r;
    em_cnt_nxt  = em_cnt_r;
    if (em_take) begin
      em_busy_nxt = 1'b1;
      em_cnt_nxt  = ld_cnt;
    end else if (em_fire) begin
      em_cnt_nxt  = em_cnt_r - CNW'(1);
      em_busy_nxt = em_cnt_r != CNW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_busy_r <= 1'b0;
      em_cnt_r  <= '0;
    end else begin
      em_busy_r <= em_busy_nxt;
      em_cnt_r  <= em_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (em_take) begin
      ex_r      <= ld_x;
      ey_r      <= ld_y;
      ec_r      <= ld_c;
      em_last_r <= seg_r[NFS-1].last;
    end else if (em_fire) begin
      for (int s = 0; s < NB - 1; s++) begin
        ex_r[s] <= ex_r[s+1];
        ey_r[s] <= ey_r[s+1];
        ec_r[s] <= ec_r[s+1];
      end
    end
  end

  // back end: piece register, region products, output register
  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic                 sc;
    logic                 ec;
    logic                 last;
    logic                 eom;
  } piece_t;

  logic                  b0_v_r, b1_v_r;
  piece_t                b0_r, b1_r;
  logic signed [SW-1:0]  sumx_r, sumy_r;
  logic signed [RPW-1:0] ra_r [NUM_LINES];
  logic signed [RPW-1:0] rb_r [NUM_LINES];
  logic [REGION_W-1:0]   region_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r, out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r      <= 1'b0;
      b1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (back_en) begin
      b0_v_r      <= em_busy_r;
      b1_v_r      <= b0_v_r;
      out_valid_r <= b1_v_r;
    end
  end

  // midpoint side test from the endpoint sums
  always_comb begin
    logic signed [DW-1:0] d;
    region_nxt = '0;
    for (int k = 0; k < NUM_LINES; k++) begin
      d = DW'(ra_r[k]) + DW'(rb_r[k]) + (DW'(cc[k]) <<< (9 + F));
      region_nxt[k] = use_m[k] && !d[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      b0_r.sx   <= ex_r[0];
      b0_r.sy   <= ey_r[0];
      b0_r.ex   <= ex_r[1];
      b0_r.ey   <= ey_r[1];
      b0_r.sc   <= ec_r[0];
      b0_r.ec   <= ec_r[1];
      b0_r.last <= em_cnt_r == CNW'(1);
      b0_r.eom  <= (em_cnt_r == CNW'(1)) && em_last_r;
      sumx_r    <= SW'(ex_r[0]) + SW'(ex_r[1]);
      sumy_r    <= SW'(ey_r[0]) + SW'(ey_r[1]);
      b1_r      <= b0_r;
      for (int k = 0; k < NUM_LINES; k++) begin
        ra_r[k] <= ca[k] * sumx_r;
        rb_r[k] <= cb[k] * sumy_r;
      end
      out_data_r <= {2'b00, region_nxt, b1_r.ec, b1_r.sc,
                     sat16(32'(b1_r.ey)), sat16(32'(b1_r.ex)),
                     sat16(32'(b1_r.sy)), sat16(32'(b1_r.sx))};
      out_last_r <= b1_r.last;
      out_user_r <= b1_r.eom;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  // region bits of lines not in use
  logic [REGION_W-1:0] unused_region;
  always_comb begin
    unused_region = '1;
    for (int k = 0; k < NUM_LINES; k++) unused_region[k] = !use_m[k];
  end

  // a busy emitter always has a piece left
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    em_busy_r |-> em_cnt_r != '0)
    else $error("emitter busy with no piece left");

  // end of model only on the last piece of a segment
  a_eom_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("end_of_model without last_piece");

  // a piece that is not the last ends at a cut
  a_mid_cut: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[65])
    else $error("inner piece end not marked as cut");

  // no region bit for a line not in use
  a_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[69:66] & unused_region) == '0)
    else $error("region bit set for unused line");

  // the front only advances when the result side moves
  a_front: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tready))
    else $error("input taken while output stalled");

endmodule
